// ----- design/rsq_pkg.sv -----
package rsq_pkg;

   // largest final sample count the design is built for
   localparam int MAX_SAMPLES_DEFAULT = 255;
   // sample count at which the early check runs
   localparam int QUICK_CHECK_COUNT = 3;

   // configuration reset values
   localparam logic [15:0] MIN_RES_RESET    = 16'd3000;
   localparam logic [15:0] MAX_RES_RESET    = 16'd9000;
   localparam logic [15:0] MAX_SPREAD_RESET = 16'd350;
   localparam logic [7:0]  SAMPLES_RESET    = 8'd20;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RES    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RES    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPREAD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES    = 3'd3;

   // input kinds
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // result status codes
   localparam logic [2:0] ST_MORE   = 3'd0;
   localparam logic [2:0] ST_PASS   = 3'd1;
   localparam logic [2:0] ST_MEAN   = 3'd2;
   localparam logic [2:0] ST_SPREAD = 3'd3;
   localparam logic [2:0] ST_INFO   = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic load_in;
      logic update;
      logic bound;
      logic judge;
      logic div_step;
      logic load_out;
   } rsq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sample_in_trial;
   } rsq_stat_type;

endpackage

// ----- design/rsq_ctrl.sv -----
module rsq_ctrl
   import rsq_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsq_stat_type stat,
   output rsq_cmd_type  cmd
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = 16 + CNT_W;
   localparam int ITER_W = $clog2(SUM_W);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPDATE = 3'd1;
   localparam logic [2:0] S_BOUND  = 3'd2;
   localparam logic [2:0] S_JUDGE  = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.sample_in_trial ? S_BOUND : S_FINISH;
         end
         S_BOUND: begin
            cmd.bound = 1'b1;
            state_in  = S_JUDGE;
         end
         S_JUDGE: begin
            cmd.judge = 1'b1;
            iter_in   = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SUM_W - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_UPDATE)
      else $error("accepted transaction did not move to update");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && iter_ff == ITER_W'(SUM_W - 1) |=> state_ff == S_FINISH)
      else $error("divider did not finish after last step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while pending");

endmodule

// ----- design/rsq_dp.sv -----
module rsq_dp
   import rsq_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsq_cmd_type          cmd,
   output rsq_stat_type         stat,
   input  logic                 req_kind,
   input  logic [15:0]          req_resistance,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_mean,
   output logic [15:0]          rsp_spread,
   output logic [7:0]           rsp_sample_count
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = 16 + CNT_W;

   logic [15:0] min_res_ff, max_res_ff, max_spread_ff;
   logic [7:0]  samples_ff;

   logic        kind_ff;
   logic [15:0] res_in_ff;

   logic             active_ff;
   logic [CNT_W-1:0] collected_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [15:0]      low_ff, high_ff;

   logic [SUM_W-1:0] lo_bound_ff, hi_bound_ff;
   logic [15:0]      spread_ff;
   logic [CNT_W-1:0] fcount_ff;
   logic [2:0]       status_ff;
   logic [SUM_W-1:0] quot_ff;
   logic [CNT_W:0]   rem_ff;

   logic [2:0]       status_out_ff;
   logic [15:0]      mean_out_ff, spread_out_ff;
   logic [7:0]       count_out_ff;

   logic [SUM_W-1:0] lo_prod, hi_prod;
   logic [7:0]       fcount_sat;
   logic [2:0]       judge_code, status_in;
   logic [CNT_W:0]   rem_sh, rem_sub;

   assign csr_ready            = 1'b1;
   assign stat.sample_in_trial = (kind_ff == KIND_SAMPLE) && active_ff;

   assign lo_prod = SUM_W'(min_res_ff) * SUM_W'(collected_ff);
   assign hi_prod = SUM_W'(max_res_ff) * SUM_W'(collected_ff);

   // zero means one, larger than the build limit saturates
   always_comb begin
      if (samples_ff == '0) begin
         fcount_sat = 8'd1;
      end else if (samples_ff > 8'(MAX_SAMPLES)) begin
         fcount_sat = 8'(MAX_SAMPLES);
      end else begin
         fcount_sat = samples_ff;
      end
   end

   // mean test first, then spread test
   always_comb begin
      if (sum_ff < lo_bound_ff || sum_ff > hi_bound_ff) begin
         judge_code = ST_MEAN;
      end else if (spread_ff > max_spread_ff) begin
         judge_code = ST_SPREAD;
      end else begin
         judge_code = ST_MORE;
      end
      status_in = ST_MORE;
      if (collected_ff == CNT_W'(QUICK_CHECK_COUNT)) begin
         status_in = judge_code;
      end
      if (status_in == ST_MORE && collected_ff >= fcount_ff) begin
         status_in = (judge_code == ST_MORE) ? ST_PASS : judge_code;
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_sh  = {rem_ff[CNT_W-1:0], quot_ff[SUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, collected_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_res_ff    <= MIN_RES_RESET;
         max_res_ff    <= MAX_RES_RESET;
         max_spread_ff <= MAX_SPREAD_RESET;
         samples_ff    <= SAMPLES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_RES:    min_res_ff    <= csr_data;
            CSR_MAX_RES:    max_res_ff    <= csr_data;
            CSR_MAX_SPREAD: max_spread_ff <= csr_data;
            CSR_SAMPLES:    samples_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         collected_ff <= '0;
         sum_ff       <= '0;
         low_ff       <= 16'hFFFF;
         high_ff      <= 16'h0000;
      end else if (cmd.update) begin
         if (kind_ff == KIND_START) begin
            active_ff    <= 1'b1;
            collected_ff <= '0;
            sum_ff       <= '0;
            low_ff       <= 16'hFFFF;
            high_ff      <= 16'h0000;
         end else if (active_ff) begin
            collected_ff <= collected_ff + 1'b1;
            sum_ff       <= sum_ff + SUM_W'(res_in_ff);
            if (res_in_ff < low_ff) begin
               low_ff <= res_in_ff;
            end
            if (res_in_ff > high_ff) begin
               high_ff <= res_in_ff;
            end
         end
      end else if (cmd.judge && status_in != ST_MORE) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         kind_ff   <= req_kind;
         res_in_ff <= req_resistance;
      end
      if (cmd.update && !stat.sample_in_trial) begin
         status_ff <= ST_INFO;
         quot_ff   <= '0;
         spread_ff <= '0;
      end
      if (cmd.bound) begin
         lo_bound_ff <= lo_prod;
         hi_bound_ff <= hi_prod;
         spread_ff   <= high_ff - low_ff;
         fcount_ff   <= fcount_sat[CNT_W-1:0];
      end
      if (cmd.judge) begin
         status_ff <= status_in;
         quot_ff   <= sum_ff;
         rem_ff    <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, collected_ff}) begin
            rem_ff  <= rem_sub;
            quot_ff <= {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            quot_ff <= {quot_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         status_out_ff <= status_ff;
         mean_out_ff   <= quot_ff[15:0];
         spread_out_ff <= spread_ff;
         count_out_ff  <= 8'(collected_ff);
      end
   end

   assign rsp_status       = status_out_ff;
   assign rsp_mean         = mean_out_ff;
   assign rsp_spread       = spread_out_ff;
   assign rsp_sample_count = count_out_ff;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      collected_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond limit");

   a_low_high: assert property (@(posedge clock) disable iff (reset)
      active_ff && collected_ff != '0 |-> low_ff <= high_ff)
      else $error("lowest sample above highest sample");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> collected_ff != '0)
      else $error("divide by zero count");

endmodule

// ----- design/resistance_sample_qualifier_core.sv -----
// a sample inside a trial steps through update, bound products, check,
// 16+clog2(MAX_SAMPLES+1) divider steps (one-bit-per-cycle divider) and output load;
// start and ignored-sample transactions go from update straight to output load;
// one transaction at a time, and output load waits while a result is still pending
// reset: synchronous active high; limits return to defaults, no trial is open,
// and no result is pending
module resistance_sample_qualifier_core
   import rsq_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [15:0]          req_resistance,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_mean,
   output logic [15:0]          rsp_spread,
   output logic [7:0]           rsp_sample_count,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   // command and status between sequencer and datapath
   rsq_cmd_type  cmd;
   rsq_stat_type stat;

   // sequencer: accepts a transaction, steps through update and, for a sample in a trial,
   // bound, check and division, then parks the result in the output register
   rsq_ctrl #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: limits, trial state, bound multipliers, checks,
   // restoring divider for the mean and the output register
   rsq_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_resistance   (req_resistance),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_mean         (rsp_mean),
      .rsp_spread       (rsp_spread),
      .rsp_sample_count (rsp_sample_count)
   );

endmodule
